// ----- design/hks_pkg.sv -----
package hks_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 8;
  localparam int ADD_W    = 16;
  localparam int CNT_W    = 32;
  localparam int TOPC_W   = 5;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = 5'd10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_TOTAL,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_OUT
  } state_t;

  // verdict of the shared compare unit on one candidate
  typedef struct packed {
    logic eligible;
    logic better;
  } cmp_res_t;

endpackage

// ----- design/hks_ram.sv -----
module hks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hks_cmp.sv -----
module hks_cmp #(
  parameter int AW = 8
) (
  input  logic [hks_pkg::CNT_W-1:0] cand_val,
  input  logic [AW-1:0]             cand_key,
  input  logic [hks_pkg::CNT_W-1:0] best_val,
  input  logic                      have_best,
  input  logic [hks_pkg::CNT_W-1:0] prev_val,
  input  logic [AW-1:0]             prev_key,
  input  logic                      first_pick,
  output hks_pkg::cmp_res_t         res
);
  import hks_pkg::*;

  // a key ranks below the previous pick when its count is smaller, or equal
  // with a higher index; that replaces a per-key "already reported" mark
  always_comb begin
    res.eligible = first_pick || (cand_val < prev_val) ||
                   ((cand_val == prev_val) && (cand_key > prev_key));
    res.better   = !have_best || (cand_val > best_val);
  end

endmodule

// ----- design/hks_seq.sv -----
module hks_seq #(
  parameter int NUM_KEYS = 256,
  parameter int MAX_TOP  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hks_pkg::OP_W-1:0]          in_op,
  input  logic [hks_pkg::KEY_W-1:0]         in_key,
  input  logic [hks_pkg::ADD_W-1:0]         in_add,
  input  logic [hks_pkg::TOPC_W-1:0]        top_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hks_pkg::KEY_W-1:0]         out_key,
  output logic [hks_pkg::CNT_W-1:0]         out_value,
  output logic [hks_pkg::CNT_W-1:0]         out_total,
  output logic                              out_last,
  output logic                              ram_we,
  output logic [$clog2(NUM_KEYS)-1:0]       ram_waddr,
  output logic [hks_pkg::CNT_W-1:0]         ram_wdata,
  output logic [$clog2(NUM_KEYS)-1:0]       ram_raddr,
  input  logic [hks_pkg::CNT_W-1:0]         ram_rdata
);
  import hks_pkg::*;

  localparam int AW  = $clog2(NUM_KEYS);
  localparam int LIM = (MAX_TOP < NUM_KEYS - 1) ? MAX_TOP : NUM_KEYS - 1;
  localparam int CW  = $clog2(MAX_TOP + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_KEYS - 1);

  state_t state_r, state_nxt;

  logic [AW-1:0]    scan_addr_r, scan_addr_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]    pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]    key_r, key_nxt;
  logic [ADD_W-1:0] add_r, add_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    picks_r, picks_nxt;
  logic             have_r, have_nxt;
  logic             first_r, first_nxt;
  logic [CNT_W-1:0] best_val_r, best_val_nxt;
  logic [AW-1:0]    best_key_r, best_key_nxt;
  logic [CNT_W-1:0] prev_val_r, prev_val_nxt;
  logic [AW-1:0]    prev_key_r, prev_key_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [CNT_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic [31:0]      key32;
  logic [AW-1:0]    key_addr;
  logic             key_ok;
  logic [31:0]      tc32;
  logic [31:0]      n32;
  logic             empty;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sat_sum;
  logic [31:0]      best32;
  logic [CW-1:0]    picks_inc;
  logic             accept;
  logic             out_done;
  cmp_res_t         cmp_res;

  hks_cmp #(.AW(AW)) u_cmp (
    .cand_val   (ram_rdata),
    .cand_key   (pend_addr_r),
    .best_val   (best_val_r),
    .have_best  (have_r),
    .prev_val   (prev_val_r),
    .prev_key   (prev_key_r),
    .first_pick (first_r),
    .res        (cmp_res)
  );

  always_comb begin
    key32     = 32'(in_key);
    key_addr  = key32[AW-1:0];
    key_ok    = key32 < 32'(NUM_KEYS);
    tc32      = 32'(top_count);
    empty     = (tc32 == 32'd0) || (tc32 > 32'(NUM_KEYS));
    n32       = (tc32 > 32'(LIM)) ? 32'(LIM) : tc32;
    sum       = {1'b0, ram_rdata} + (CNT_W + 1)'(add_r);
    sat_sum   = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    best32    = 32'(best_key_r);
    picks_inc = picks_r + CW'(1);
    accept    = in_valid && (state_r == ST_IDLE);
    out_done  = out_valid_r && out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (scan_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_CLEAR:  state_nxt = ST_CLEAR;
            OP_ADD:    state_nxt = key_ok ? ST_ADD_WR : ST_IDLE;
            OP_REPORT: state_nxt = ST_TOTAL;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR:   state_nxt = ST_IDLE;
      ST_TOTAL:    state_nxt = empty ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (scan_addr_r == LAST_ADDR) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: state_nxt = ST_PICK;
      ST_PICK:     state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_nxt = out_last_r ? ST_IDLE : ST_SCAN;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = scan_addr_r;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        ram_raddr = (in_op == OP_REPORT) ? '0 : key_addr;
      end
      ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = key_r;
        ram_wdata = sat_sum;
      end
      ST_SCAN: begin
        ram_raddr = scan_addr_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    scan_addr_nxt = scan_addr_r;
    pend_vld_nxt  = (state_r == ST_SCAN);
    pend_addr_nxt = scan_addr_r;
    key_nxt       = key_r;
    add_nxt       = add_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    picks_nxt     = picks_r;
    have_nxt      = have_r;
    first_nxt     = first_r;
    best_val_nxt  = best_val_r;
    best_key_nxt  = best_key_r;
    prev_val_nxt  = prev_val_r;
    prev_key_nxt  = prev_key_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    if (accept) begin
      scan_addr_nxt = '0;
      key_nxt       = key_addr;
      add_nxt       = in_add;
    end
    if (state_r == ST_CLEAR || state_r == ST_SCAN) begin
      scan_addr_nxt = scan_addr_r + AW'(1);
    end
    if (state_r == ST_TOTAL) begin
      total_nxt     = ram_rdata;
      n_nxt         = n32[CW-1:0];
      picks_nxt     = '0;
      first_nxt     = 1'b1;
      have_nxt      = 1'b0;
      scan_addr_nxt = AW'(1);
    end
    if (pend_vld_r && cmp_res.eligible && cmp_res.better) begin
      have_nxt     = 1'b1;
      best_val_nxt = ram_rdata;
      best_key_nxt = pend_addr_r;
    end
    if (state_r == ST_PICK) begin
      out_valid_nxt = 1'b1;
      out_key_nxt   = best32[KEY_W-1:0];
      out_value_nxt = best_val_r;
      out_last_nxt  = (picks_inc == n_r);
      prev_val_nxt  = best_val_r;
      prev_key_nxt  = best_key_r;
      first_nxt     = 1'b0;
      picks_nxt     = picks_inc;
    end
    if (out_done) begin
      out_valid_nxt = 1'b0;
      have_nxt      = 1'b0;
      scan_addr_nxt = AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      first_r     <= 1'b1;
      picks_r     <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      first_r     <= first_nxt;
      picks_r     <= picks_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    key_r       <= key_nxt;
    add_r       <= add_nxt;
    total_r     <= total_nxt;
    best_val_r  <= best_val_nxt;
    best_key_r  <= best_key_nxt;
    prev_val_r  <= prev_val_nxt;
    prev_key_r  <= prev_key_nxt;
    out_key_r   <= out_key_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_key   = out_key_r;
  assign out_value = out_value_r;
  assign out_total = total_r;
  assign out_last  = out_last_r;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OUT))
    else $error("result shown outside output state");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SCAN_END || state_r == ST_PICK) |-> !ram_we)
    else $error("counter table written during a report");

  a_pick_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> have_r)
    else $error("scan ended with no candidate");

  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_done && out_last_r) |=> (state_r == ST_IDLE))
    else $error("report did not end after last result");

  a_picks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (picks_r <= n_r) && (picks_r != '0))
    else $error("result count out of range");

endmodule

// ----- design/histogram_top_k_select.sv -----
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tdata: op, key_index, add_count
// out     | out | out_tvalid/tready  | out_tdata: top_key, top_value, total_value; out_tlast
// cfg     | in  | cfg_wen            | cfg_wdata: top_count
//
// one compare unit and one memory read port are shared by every step
// add item: read, then saturating write back; clear item: a write sweep over all NUM_KEYS slots
// report item: read of the total, then per result a table walk (scan, scan end, pick, output),
//   with each result held until out_tready takes it
// reset starts a clearing pass over all NUM_KEYS slots, in_tready stays low meanwhile
// in_tready is high only between items; cfg writes are taken in any cycle
module histogram_top_k_select #(
  parameter int NUM_KEYS = 256,
  parameter int MAX_TOP  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: op [1:0], key_index [9:2], add_count [25:10], zero [31:26]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: top_key [7:0], top_value [39:8], total_value [71:40]
  output logic [71:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata
);
  import hks_pkg::*;

  localparam int AW = $clog2(NUM_KEYS);

  logic [TOPC_W-1:0] top_count_r;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [CNT_W-1:0] ram_rdata;

  logic [KEY_W-1:0] res_key;
  logic [CNT_W-1:0] res_value;
  logic [CNT_W-1:0] res_total;

  // report length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= TOP_COUNT_RESET;
    end else if (cfg_wen) begin
      top_count_r <= cfg_wdata;
    end
  end

  // per-key counters, slot 0 is the running total
  hks_ram #(.WIDTH(CNT_W), .DEPTH(NUM_KEYS)) u_counters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: add, clear sweep, and repeated top-k table walks
  hks_seq #(.NUM_KEYS(NUM_KEYS), .MAX_TOP(MAX_TOP)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_key    (in_tdata[9:2]),
    .in_add    (in_tdata[25:10]),
    .top_count (top_count_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_key   (res_key),
    .out_value (res_value),
    .out_total (res_total),
    .out_last  (out_tlast),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // pack result fields, lowest field first
  assign out_tdata = {res_total, res_value, res_key};

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hks_pkg::*;

  localparam int NUM_KEYS    = 256;
  localparam int MAX_TOP     = 16;
  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DIR_ROWS    = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int BIG_ADDS    = 4;
  // op code the block has no use for, must be dropped silently
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one reported key as it leaves the block
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] total;
    logic             last;
  } top_entry_t;

  // input item plus, where easy to see, the first entry of the report it starts
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [ADD_W-1:0] amount;
    logic             typed;
    logic [KEY_W-1:0] exp_key;
    logic [CNT_W-1:0] exp_count;
    logic [CNT_W-1:0] exp_total;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wen    = 1'b0;
  logic [4:0]  cfg_wdata  = '0;

  // predicted table and register
  logic [CNT_W-1:0]  key_cnt [NUM_KEYS];
  logic [TOPC_W-1:0] top_cnt_reg = TOP_COUNT_RESET;
  top_entry_t        pending_tops [$];

  dir_row_t dir_tab [DIR_ROWS];
  logic [TOPC_W-1:0] fixed_tops [5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17};

  int          mismatches = 0;
  int unsigned cycles     = 0;
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;
  int          stall_ctr  = 0;
  int          stall_mode = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  histogram_top_k_select #(
    .NUM_KEYS(NUM_KEYS),
    .MAX_TOP (MAX_TOP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    for (int i = 0; i < NUM_KEYS; i++) key_cnt[i] = '0;
  end

  // update the table for one item and queue the entries a report returns
  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [KEY_W-1:0] key,
                                       input logic [ADD_W-1:0] amount);
    bit            chosen [NUM_KEYS];
    int            n;
    int            best;
    bit            have;
    logic [CNT_W:0] sum;
    top_entry_t    e;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NUM_KEYS; i++) key_cnt[i] = '0;
      end
      OP_ADD: begin
        if (key < NUM_KEYS) begin
          sum = {1'b0, key_cnt[key]} + (CNT_W + 1)'(amount);
          key_cnt[key] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        end
      end
      OP_REPORT: begin
        for (int i = 0; i < NUM_KEYS; i++) chosen[i] = 1'b0;
        n = top_cnt_reg;
        if (n > NUM_KEYS) n = 0;
        if (n > MAX_TOP) n = MAX_TOP;
        if (n > NUM_KEYS - 1) n = NUM_KEYS - 1;
        for (int k = 0; k < n; k++) begin
          best = 0;
          have = 1'b0;
          // slot 0 is the total and never a candidate; ties keep the lower key
          for (int j = 1; j < NUM_KEYS; j++) begin
            if (!chosen[j] && (!have || key_cnt[j] > key_cnt[best])) begin
              best = j;
              have = 1'b1;
            end
          end
          chosen[best] = 1'b1;
          e.key   = best[KEY_W-1:0];
          e.count = key_cnt[best];
          e.total = key_cnt[0];
          e.last  = (k == n - 1);
          pending_tops = {pending_tops, e};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // drive one item in bursts with random gaps, predict it once taken
  task automatic send_item(input dir_row_t row);
    int base;
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    if (gaps_on) burst_left--;
    in_tdata  <= {6'b0, row.amount, row.key, row.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    base = pending_tops.size();
    predict_item(row.op, row.key, row.amount);
    if (row.typed && pending_tops.size() > base) begin
      pending_tops[base].key   = row.exp_key;
      pending_tops[base].count = row.exp_count;
      pending_tops[base].total = row.exp_total;
    end
  endtask

  // register writes only once the block is quiet; a clear may still be running
  task automatic set_top_count(input logic [TOPC_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_tops.size() != 0) @(posedge clk);
    repeat (NUM_KEYS + 8) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen     <= 1'b0;
    top_cnt_reg = value;
  endtask

  // receiver stall pattern: always ready, coin flip, or ready only when the stall counter is a multiple of four
  always @(posedge clk) begin
    stall_ctr++;
    if (stall_ctr % 50 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= (stall_ctr % 4 == 0);
    endcase
  end

  // compare every accepted result with the oldest prediction
  always @(posedge clk) begin : watch_results
    top_entry_t e;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_tops.size() == 0) begin
        $display("%0t: result with no item pending, expected none, actual key %0d value 0x%0h",
                 $time, out_tdata[7:0], out_tdata[39:8]);
        mismatches++;
      end else begin
        e = pending_tops.pop_front();
        check_field("top_key", 32'(e.key), 32'(out_tdata[7:0]));
        check_field("top_value", e.count, out_tdata[39:8]);
        check_field("total_value", e.total, out_tdata[71:40]);
        check_field("last", 32'(e.last), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    dir_row_t         r;
    int               counted;
    int               w;
    logic [KEY_W-1:0] hot_key;

    // top_count is at its reset value of 10 for this table
    dir_tab[0]  = '{OP_REPORT, 8'd0,   16'h0000, 1'b1, 8'd1,   32'h0,     32'h0};
    dir_tab[1]  = '{OP_ADD,    8'd255, 16'hFFFF, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[2]  = '{OP_ADD,    8'd0,   16'hFFFF, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[3]  = '{OP_ADD,    8'd1,   16'h0000, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[4]  = '{OP_ADD,    8'd128, 16'h8000, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[5]  = '{OP_REPORT, 8'd0,   16'h0000, 1'b1, 8'd255, 32'hFFFF,  32'hFFFF};
    // unused op with alternating bit patterns, nothing may change
    dir_tab[6]  = '{OP_UNUSED, 8'hAA,  16'h5555, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[7]  = '{OP_UNUSED, 8'h55,  16'hAAAA, 1'b0, 8'd0,   32'h0,     32'h0};
    // tie with key 255, lower key wins
    dir_tab[8]  = '{OP_ADD,    8'd7,   16'hFFFF, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[9]  = '{OP_REPORT, 8'd0,   16'h0000, 1'b1, 8'd7,   32'hFFFF,  32'hFFFF};
    dir_tab[10] = '{OP_CLEAR,  8'hFF,  16'hFFFF, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[11] = '{OP_REPORT, 8'd0,   16'h0000, 1'b1, 8'd1,   32'h0,     32'h0};
    dir_tab[12] = '{OP_ADD,    8'd0,   16'h0001, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[13] = '{OP_ADD,    8'd42,  16'h0001, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[14] = '{OP_ADD,    8'd42,  16'hFFFF, 1'b0, 8'd0,   32'h0,     32'h0};
    dir_tab[15] = '{OP_REPORT, 8'd0,   16'h0000, 1'b1, 8'd42,  32'h10000, 32'h1};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_tab[i]);

    // random phases, each under its own top_count, extremes first
    for (int p = 0; p < PHASES; p++) begin
      set_top_count(p < 5 ? fixed_tops[p] : TOPC_W'($urandom_range(2, 15)));
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        w = $urandom_range(0, 99);
        r.op = (w < 72) ? OP_ADD : (w < 86) ? OP_REPORT : (w < 91) ? OP_CLEAR : OP_UNUSED;
        // a small hot set of keys makes ties and reordering common
        w = $urandom_range(0, 9);
        r.key = (w < 6) ? KEY_W'($urandom_range(1, 12)) :
                (w == 6) ? '0 : KEY_W'($urandom_range(0, 255));
        w = $urandom_range(0, 9);
        r.amount = (w < 3) ? ADD_W'($urandom_range(0, 3)) :
                   (w == 3) ? '1 : (w == 4) ? '0 : ADD_W'($urandom_range(0, 65535));
        r.typed     = 1'b0;
        r.exp_key   = '0;
        r.exp_count = '0;
        r.exp_total = '0;
        send_item(r);
        if (r.op != OP_UNUSED) counted++;
      end
    end

    // largest adds to one key and the total, back to back
    set_top_count(5'd2);
    gaps_on = 1'b0;
    hot_key = KEY_W'($urandom_range(1, 255));
    r = '{OP_CLEAR, 8'd0, 16'h0000, 1'b0, 8'd0, 32'h0, 32'h0};
    send_item(r);
    for (int i = 0; i < BIG_ADDS; i++) begin
      r = '{OP_ADD, hot_key, 16'hFFFF, 1'b0, 8'd0, 32'h0, 32'h0};
      send_item(r);
      r = '{OP_ADD, 8'd0, 16'hFFFF, 1'b0, 8'd0, 32'h0, 32'h0};
      send_item(r);
    end
    r = '{OP_REPORT, 8'd0, 16'h0000, 1'b1, hot_key, 32'h0003_FFFC, 32'h0003_FFFC};
    send_item(r);
    in_tvalid <= 1'b0;

    while (pending_tops.size() != 0) @(posedge clk);
    repeat (NUM_KEYS + 8) @(posedge clk);
    if (mismatches == 0 && pending_tops.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
